>>> rtl/hpq_pkg.sv
`timescale 1ns / 1ps

package hpq_pkg;

  // Request codes carried on the req_type field.
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  // Heap order codes held in the configuration register.
  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

  localparam int KeyW   = 32;
  localparam int CountW = 6;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef logic signed [KeyW-1:0] key_t;

  // True when key a must sit above key b under the given order.
  function automatic logic beats(key_t a, key_t b, logic order);
    beats = (order == ORDER_MIN) ? (a < b) : (a > b);
  endfunction

endpackage

>>> rtl/hpq_ram.sv
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  hpq_pkg::key_t        wdata,
  input  logic [AW-1:0]        raddr,
  output hpq_pkg::key_t        rdata
);
  import hpq_pkg::*;

  key_t mem [DEPTH];
  key_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A read of the entry written in the same cycle returns the new word.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/hpq_engine.sv
`timescale 1ns / 1ps

module hpq_engine #(
  parameter int CAPACITY = 32,
  parameter int AW       = 5,
  parameter int CW       = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   accept,
  input  logic                   req_type,
  input  hpq_pkg::key_t          key_in,
  input  logic                   heap_order,
  output logic                   busy,
  output logic                   ram_we,
  output logic [AW-1:0]          ram_waddr,
  output hpq_pkg::key_t          ram_wdata,
  output logic [AW-1:0]          ram_raddr,
  input  hpq_pkg::key_t          ram_rdata,
  output logic                   res_valid,
  output logic [1:0]             res_status,
  output logic [hpq_pkg::CountW-1:0] res_count,
  output hpq_pkg::key_t          res_root
);
  import hpq_pkg::*;

  localparam int XW = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_GET_LAST,
    S_SIFT_UP,
    S_SD_L,
    S_SD_R,
    S_WR_KEY
  } state_t;

  state_t            state_r, state_nxt;
  key_t              key_r, key_nxt;
  key_t              left_r, left_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              first_r, first_nxt;
  key_t              root_r, root_nxt;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [CountW-1:0] out_count_r;
  key_t              out_root_r;

  logic              done;
  status_t           done_status;
  logic              we;
  logic [AW-1:0]     waddr;
  key_t              wdata;
  logic [AW-1:0]     raddr;

  logic [XW-1:0]     lch;
  logic [XW-1:0]     rch;
  logic [XW-1:0]     cnt_x;
  logic [AW-1:0]     up_idx;

  assign lch    = {1'b0, pos_r, 1'b1};
  assign rch    = lch + XW'(1);
  assign cnt_x  = XW'(count_r);
  assign up_idx = AW'((pos_r - AW'(1)) >> 1);

  always_comb begin
    logic             take_r;
    key_t             best;
    logic [XW-1:0]    bidx;
    logic [XW-1:0]    blch;
    logic [AW-1:0]    pidx;

    state_nxt   = state_r;
    key_nxt     = key_r;
    left_nxt    = left_r;
    pos_nxt     = pos_r;
    count_nxt   = count_r;
    first_nxt   = first_r;
    done        = 1'b0;
    done_status = ST_DONE;
    we          = 1'b0;
    waddr       = pos_r;
    wdata       = key_r;
    raddr       = '0;
    take_r      = 1'b0;
    best        = ram_rdata;
    bidx        = lch;
    blch        = '0;
    pidx        = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt   = key_in;
          first_nxt = 1'b0;
          if (req_type == REQ_INSERT) begin
            if (count_r >= CW'(CAPACITY)) begin
              done        = 1'b1;
              done_status = ST_FULL;
            end else begin
              count_nxt = count_r + CW'(1);
              pos_nxt   = AW'(count_r);
              if (count_r == '0) begin
                we    = 1'b1;
                waddr = '0;
                wdata = key_in;
                done  = 1'b1;
              end else begin
                pidx      = AW'((count_r - CW'(1)) >> 1);
                raddr     = pidx;
                state_nxt = S_SIFT_UP;
              end
            end
          end else if (count_r == '0) begin
            done        = 1'b1;
            done_status = ST_EMPTY;
          end else begin
            raddr     = '0;
            pos_nxt   = '0;
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (ram_rdata == key_r) begin
          count_nxt = count_r - CW'(1);
          if (CW'(pos_r) == count_r - CW'(1)) begin
            done      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            raddr     = AW'(count_r - CW'(1));
            state_nxt = S_GET_LAST;
          end
        end else if (CW'(pos_r) + CW'(1) == count_r) begin
          done        = 1'b1;
          done_status = ST_MISSING;
          state_nxt   = S_IDLE;
        end else begin
          pos_nxt = pos_r + AW'(1);
          raddr   = pos_r + AW'(1);
        end
      end

      S_GET_LAST: begin
        key_nxt   = ram_rdata;
        first_nxt = 1'b1;
        if (pos_r != '0) begin
          raddr     = up_idx;
          state_nxt = S_SIFT_UP;
        end else if (lch < cnt_x) begin
          raddr     = AW'(lch);
          state_nxt = S_SD_L;
        end else begin
          we        = 1'b1;
          wdata     = ram_rdata;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SIFT_UP: begin
        first_nxt = 1'b0;
        if (beats(key_r, ram_rdata, heap_order)) begin
          we      = 1'b1;
          wdata   = ram_rdata;
          pos_nxt = up_idx;
          if (up_idx != '0) begin
            raddr = AW'((up_idx - AW'(1)) >> 1);
          end else begin
            state_nxt = S_WR_KEY;
          end
        end else if (first_r && (lch < cnt_x)) begin
          // The moved key does not beat its parent: sift it down instead.
          raddr     = AW'(lch);
          state_nxt = S_SD_L;
        end else begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SD_L: begin
        left_nxt = ram_rdata;
        if (rch < cnt_x) begin
          raddr     = AW'(rch);
          state_nxt = S_SD_R;
        end else if (beats(ram_rdata, key_r, heap_order)) begin
          we        = 1'b1;
          wdata     = ram_rdata;
          pos_nxt   = AW'(lch);
          state_nxt = S_WR_KEY;
        end else begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_SD_R: begin
        take_r = beats(ram_rdata, left_r, heap_order);
        best   = take_r ? ram_rdata : left_r;
        bidx   = take_r ? rch : lch;
        blch   = {1'b0, AW'(bidx), 1'b1};
        if (beats(best, key_r, heap_order)) begin
          we      = 1'b1;
          wdata   = best;
          pos_nxt = AW'(bidx);
          if (blch < cnt_x) begin
            raddr     = AW'(blch);
            state_nxt = S_SD_L;
          end else begin
            state_nxt = S_WR_KEY;
          end
        end else begin
          we        = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_WR_KEY: begin
        we        = 1'b1;
        done      = 1'b1;
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    root_nxt = (we && (waddr == '0)) ? wdata : root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      first_r     <= first_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    left_r       <= left_nxt;
    pos_r        <= pos_nxt;
    root_r       <= root_nxt;
    out_status_r <= done_status;
    out_count_r  <= CountW'(count_nxt);
    out_root_r   <= (count_nxt == '0) ? key_t'(0) : root_nxt;
  end

  assign busy       = (state_r != S_IDLE);
  assign ram_we     = we;
  assign ram_waddr  = waddr;
  assign ram_wdata  = wdata;
  assign ram_raddr  = raddr;
  assign res_valid  = out_valid_r;
  assign res_status = out_status_r;
  assign res_count  = out_count_r;
  assign res_root   = out_root_r;

endmodule

>>> rtl/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Word
// in_       input      start high, busy low      in_req_type, in_key_value
// out_      output     out_valid, one cycle      out_status, out_entry_count, out_root_key
// cfg_      input      cfg_valid and cfg_ready   cfg_heap_order
//
// An insert into an empty heap writes the key at once; otherwise it reads the
// new slot's parent, moves each parent that the key beats down a level, and
// writes the key where it stops. A remove scans the keys one per cycle through
// the single read port of the key memory, fetches the last key and its parent
// or left child, then sifts it up or down, reading the children of each level.
// The result strobe comes in the cycle after a request's last write, if any.
// Reset clears the count and order register; the key memory is not cleared.
// The receiver cannot stall: every result is shown for exactly one cycle.

module binary_heap_priority_queue #(
  parameter int CAPACITY = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_req_type,
  input  logic signed [31:0]            in_key_value,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [5:0]                    out_entry_count,
  output logic signed [31:0]            out_root_key,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_heap_order
);
  import hpq_pkg::*;

  // Index width for the key memory and width of the count, which must hold
  // CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic          heap_order_r;
  logic          accept;
  logic          eng_busy;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  key_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  key_t          ram_rdata;

  // A request is taken only while the engine is idle.
  assign accept    = start && !eng_busy;
  assign busy      = eng_busy;

  // The order register is written between requests; taking the word only
  // while idle and while no request is offered keeps a request from seeing
  // the order change under it.
  assign cfg_ready = !eng_busy && !start;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_order_r <= ORDER_MAX;
    end else if (cfg_valid && cfg_ready) begin
      heap_order_r <= cfg_heap_order;
    end
  end

  hpq_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  hpq_engine #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .key_in     (in_key_value),
    .heap_order (heap_order_r),
    .busy       (eng_busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .res_valid  (out_valid),
    .res_status (out_status),
    .res_count  (out_entry_count),
    .res_root   (out_root_key)
  );

  // A result is only shown once the engine has gone back to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the engine is busy");

  // Every accepted request either keeps the engine busy or answers at once.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request produced neither work nor a result");

  // An empty heap reports a zero root key.
  a_empty_root: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_entry_count == 6'd0) && (CAPACITY < 64)) |-> (out_root_key == 32'sd0))
    else $error("empty heap reported a nonzero root key");

  // A full answer always comes with the count at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == ST_FULL)) |-> (out_entry_count == 6'(CAPACITY)))
    else $error("full status with the count below capacity");

endmodule

>>> tb/sv/tb_binary_heap_priority_queue.sv
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;
  import hpq_pkg::*;

  // The block is built with the default depth, and the shadow heap below
  // uses the same depth.
  localparam int HEAP_DEPTH = 32;

  // The directed table is followed by this many random request words.
  localparam int RANDOM_WORDS = 1600;

  // A remove may scan the whole store and then sift over every level. The
  // watchdog limit below is far above that worst case.
  localparam int SETTLE_CYCLES  = 16;
  localparam int END_CYCLES     = 64;
  localparam int WATCHDOG_LIMIT = 4000;

  localparam key_t KEY_TOP    = 32'sh7FFF_FFFF;
  localparam key_t KEY_BOTTOM = 32'sh8000_0000;

  // One result word as the block reports it.
  typedef struct packed {
    status_t      status;
    logic [5:0]   count;
    key_t         root;
  } heap_result_t;

  // A row of the directed table is either a request word or a write of the
  // heap order register. Rows marked pinned carry their expected result,
  // which can be read straight off the request; the rest go to the shadow heap.
  typedef enum logic {ROW_WORD, ROW_ORDER} row_kind_t;

  typedef struct {
    row_kind_t    kind;
    logic         req;
    key_t         key;
    logic         order;
    logic         pinned;
    heap_result_t want;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = REQ_INSERT;
  key_t        in_key_value = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [5:0]  out_entry_count;
  key_t        out_root_key;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_heap_order = ORDER_MAX;

  binary_heap_priority_queue #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_key_value   (in_key_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_entry_count(out_entry_count),
    .out_root_key   (out_root_key),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_heap_order (cfg_heap_order)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Shadow copy of the heap. It is updated at the clock edge that accepts a
  // request word or a register write, so it always matches what the block
  // holds once every result up to that word has come out.
  key_t         heap_keys [HEAP_DEPTH];
  int           held_count = 0;
  logic         heap_order_shadow = ORDER_MAX;

  heap_result_t pending_results [$];

  // The pinned expectation for the word now on the input ports, set by the
  // driver together with the word.
  logic         word_pinned = 1'b0;
  heap_result_t word_want;

  int           mismatches = 0;
  int           quiet_cycles = 0;
  int           status_seen [4] = '{0, 0, 0, 0};
  int           inserts_sent = 0;
  int           removes_sent = 0;
  int           order_writes = 0;
  int           deepest_fill = 0;

  // True if key a has to sit above key b under the current order. Ties never
  // win, so equal keys stay where they are.
  function automatic logic outranks(key_t a, key_t b);
    if (heap_order_shadow == ORDER_MIN) begin
      return a < b;
    end
    return a > b;
  endfunction

  // Move the key in slot pos toward the root while it beats its parent.
  function automatic void bubble_up(int pos);
    key_t climber;
    int   parent;
    logic moving;
    climber = heap_keys[pos];
    moving  = 1'b1;
    while (pos > 0 && moving) begin
      parent = (pos - 1) / 2;
      if (outranks(climber, heap_keys[parent])) begin
        heap_keys[pos] = heap_keys[parent];
        pos = parent;
      end else begin
        moving = 1'b0;
      end
    end
    heap_keys[pos] = climber;
  endfunction

  // Apply one request to the shadow heap and return the result it must give.
  function automatic heap_result_t heap_apply(logic req, key_t key);
    heap_result_t res;
    int           hit;
    int           pos;
    int           child;
    key_t         sinker;
    logic         moving;
    res.status = ST_DONE;
    if (req == REQ_INSERT) begin
      if (held_count >= HEAP_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        heap_keys[held_count] = key;
        held_count++;
        bubble_up(held_count - 1);
      end
    end else if (held_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // The first equal key in slot order is the one removed.
      hit = -1;
      for (int slot = 0; slot < held_count; slot++) begin
        if (hit < 0 && heap_keys[slot] == key) begin
          hit = slot;
        end
      end
      if (hit < 0) begin
        res.status = ST_MISSING;
      end else begin
        held_count--;
        heap_keys[hit] = heap_keys[held_count];
        if (hit < held_count) begin
          if (hit > 0 && outranks(heap_keys[hit], heap_keys[(hit - 1) / 2])) begin
            // The last key landed under a parent it beats, so it climbs.
            bubble_up(hit);
          end else begin
            // Otherwise it sinks. A lone left child in the last slot is
            // weighed as well, and the right child only wins outright.
            pos    = hit;
            sinker = heap_keys[pos];
            moving = 1'b1;
            while (moving && 2 * pos + 1 < held_count) begin
              child = 2 * pos + 1;
              if (child + 1 < held_count && outranks(heap_keys[child + 1], heap_keys[child])) begin
                child++;
              end
              if (outranks(heap_keys[child], sinker)) begin
                heap_keys[pos] = heap_keys[child];
                pos = child;
              end else begin
                moving = 1'b0;
              end
            end
            heap_keys[pos] = sinker;
          end
        end
      end
    end
    res.count = held_count[5:0];
    res.root  = (held_count > 0) ? heap_keys[0] : '0;
    return res;
  endfunction

  // Everything is sampled here at the rising edge, before the block's own
  // updates of this edge can be seen. A result is checked before the word
  // accepted at the same edge is predicted, since it belongs to an older word.
  always @(posedge clk) begin
    heap_result_t got;
    heap_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        got.status = status_t'(out_status);
        got.count  = out_entry_count;
        got.root   = out_root_key;
        if (pending_results.size() == 0) begin
          $error("result word with no request pending: status %0d count %0d root %0d",
                 out_status, out_entry_count, out_root_key);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          status_seen[out_status]++;
          if (got.status !== want.status) begin
            $error("out_status: expected %0d, got %0d", want.status, out_status);
            mismatches++;
          end
          if (got.count !== want.count) begin
            $error("out_entry_count: expected %0d, got %0d", want.count, got.count);
            mismatches++;
          end
          if (got.root !== want.root) begin
            $error("out_root_key: expected %0d, got %0d", want.root, got.root);
            mismatches++;
          end
        end
      end

      if (start && !busy) begin
        want = heap_apply(in_req_type, in_key_value);
        pending_results.push_back(word_pinned ? word_want : want);
        if (held_count > deepest_fill) begin
          deepest_fill = held_count;
        end
      end

      if (cfg_valid && cfg_ready) begin
        heap_order_shadow = cfg_heap_order;
        order_writes++;
      end

      // The watchdog only counts cycles in which no word moves on any port.
      if (out_valid || (start && !busy) || (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, pending_results.size());
        $display("binary_heap_priority_queue regression: fail");
        $finish;
      end
    end
  end

  // Present one request word at the falling edge and hold it until the block
  // takes it. The task returns right after the accepting edge, so a following
  // word goes out at the next falling edge with start left high.
  task automatic send_word(logic req, key_t key, logic pinned, heap_result_t want);
    @(negedge clk);
    in_req_type  <= req;
    in_key_value <= key;
    start        <= 1'b1;
    word_pinned  = pinned;
    word_want    = want;
    if (req == REQ_INSERT) begin
      inserts_sent++;
    end else begin
      removes_sent++;
    end
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Drop start for a gap of the given number of cycles.
  task automatic rest(int gap);
    @(negedge clk);
    start <= 1'b0;
    repeat (gap - 1) @(negedge clk);
  endtask

  // Hold off until every result is back and the block has gone quiet.
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // The order register is only written with the block idle.
  task automatic write_order(logic order);
    settle();
    cfg_valid      <= 1'b1;
    cfg_heap_order <= order;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Half the keys come from a narrow band so that removes hit and ties are
  // common; the rest are the extremes, zero, minus one or full 32-bit values.
  function automatic key_t pick_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 3))
        0: return KEY_TOP;
        1: return KEY_BOTTOM;
        2: return '0;
        default: return -1;
      endcase
    end else if (pick <= 5) begin
      return key_t'($urandom_range(0, 15)) - 8;
    end
    return key_t'($urandom);
  endfunction

  initial begin
    script_row_t  script [$];
    script_row_t  row;
    heap_result_t none;
    int           random_words;
    int           phase;
    int           phase_len;
    int           insert_pct;
    int           burst_left;
    logic         req;
    key_t         key;

    none = '{ST_DONE, 6'd0, 32'sd0};

    // Reset state and the extremes have pinned results; the deeper rows walk
    // ties, the order flip with keys held, a moved key that has to climb after
    // a remove, and the root removal that sinks past a lone child.
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd5, ORDER_MAX, 1'b1, '{ST_EMPTY, 6'd0, 32'sd0}});
    script.push_back('{ROW_WORD, REQ_INSERT, KEY_TOP, ORDER_MAX, 1'b1, '{ST_DONE, 6'd1, KEY_TOP}});
    script.push_back('{ROW_WORD, REQ_INSERT, KEY_BOTTOM, ORDER_MAX, 1'b1,
                       '{ST_DONE, 6'd2, KEY_TOP}});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd0, ORDER_MAX, 1'b1,
                       '{ST_MISSING, 6'd2, KEY_TOP}});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd3, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd3, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, KEY_TOP, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_ORDER, REQ_INSERT, 32'sd0, ORDER_MIN, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd1, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd3, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, KEY_BOTTOM, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd3, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd1, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd1, ORDER_MAX, 1'b1, '{ST_EMPTY, 6'd0, 32'sd0}});
    script.push_back('{ROW_ORDER, REQ_INSERT, 32'sd0, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd100, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd50, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd90, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd40, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd45, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd80, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_INSERT, 32'sd85, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd40, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd100, ORDER_MAX, 1'b0, none});
    script.push_back('{ROW_WORD, REQ_REMOVE, 32'sd90, ORDER_MAX, 1'b0, none});

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      row = script[r];
      if (row.kind == ROW_ORDER) begin
        write_order(row.order);
      end else begin
        send_word(row.req, row.key, row.pinned, row.want);
      end
    end

    // The random part runs in phases. The first phase leans on inserts so the
    // store fills up and overflows, the second drains it past empty, and later
    // phases pick a lean at random. Removes mostly name a key that is held.
    random_words = 0;
    phase        = 0;
    burst_left   = $urandom_range(1, 12);
    while (random_words < RANDOM_WORDS) begin
      if (phase < 2 || $urandom_range(0, 1) == 1) begin
        write_order(logic'($urandom_range(0, 1)));
      end else if ($urandom_range(0, 3) == 0) begin
        settle();
      end
      case ((phase < 2) ? phase : $urandom_range(0, 2))
        0: insert_pct = 80;
        1: insert_pct = 20;
        default: insert_pct = 50;
      endcase
      phase_len = (phase < 2) ? 120 : $urandom_range(30, 120);

      for (int k = 0; k < phase_len; k++) begin
        req = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_REMOVE;
        if (req == REQ_REMOVE && held_count > 0 && $urandom_range(0, 9) < 7) begin
          key = heap_keys[$urandom_range(0, held_count - 1)];
        end else begin
          key = pick_key();
        end
        send_word(req, key, 1'b0, none);
        random_words++;

        // Bursts of random length with gaps between them; now and then a long
        // burst gives a stretch with no idling at all.
        burst_left--;
        if (burst_left == 0) begin
          rest($urandom_range(1, 8));
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                   : $urandom_range(1, 12);
        end
      end
      phase++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (END_CYCLES) @(posedge clk);

    $display("covered %0d inserts and %0d removes over %0d order writes, fill reached %0d",
             inserts_sent, removes_sent, order_writes, deepest_fill);
    $display("results by status: done %0d, full %0d, empty %0d, not found %0d",
             status_seen[ST_DONE], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_MISSING]);
    if (mismatches == 0) begin
      $display("binary_heap_priority_queue regression: pass");
    end else begin
      $display("binary_heap_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_engine.sv
rtl/binary_heap_priority_queue.sv
tb/sv/tb_binary_heap_priority_queue.sv
